// ===== rtl/lbw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbw_pkg: shared types and constants
// Word formats, queue entry, configuration view and divider widths for the
// lagrange basis weight unit.
// ----------------------------------------------------------------------------
package lbw_pkg;

	localparam int MAX_NODES_DEF = 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [1:0] REG_BLADE_ROOT = 2'd1;
	localparam logic [1:0] REG_BLADE_TIP  = 2'd2;
	localparam logic [1:0] REG_MATCH_TOL  = 2'd3;

	localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;
	localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] NEG_MIN = 32'sh8000_0000;

	// divider: magnitude dividend and divisor widths
	localparam int DVD_W = 58;
	localparam int DVS_W = 33;

	typedef struct packed {
		logic              opcode;
		logic [2:0]        node_index;
		logic signed [31:0] coordinate;
	} in_t;

	typedef struct packed {
		logic [2:0]         weight_index;
		logic signed [31:0] weight;
		logic signed [31:0] normalized_position;
		logic               error_flag;
		logic               last;
	} out_t;

	typedef struct packed {
		logic               is_eval;
		logic               wr_ok;
		logic [2:0]         node_index;
		logic signed [31:0] coordinate;
	} entry_t;

	typedef struct packed {
		logic [3:0]         n;
		logic signed [31:0] root;
		logic signed [31:0] tip;
		logic [24:0]        tol;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/lbw_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbw_div: restoring magnitude divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module lbw_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [lbw_pkg::DVD_W-1:0]   dividend,
	input  wire logic [lbw_pkg::DVS_W-1:0]   divisor,
	output logic                             done,
	output logic [lbw_pkg::DVD_W-1:0]        quotient
);
	localparam int DW = lbw_pkg::DVD_W;
	localparam int VW = lbw_pkg::DVS_W;
	localparam int CW = $clog2(DW + 1);

	logic          run_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] dvd_q;
	logic [VW-1:0] dvs_q;
	logic          done_q;
	logic [VW:0]   sh;
	logic [VW:0]   diff;

	assign sh   = {rem_q, dvd_q[DW-1]};
	assign diff = sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= diff[VW] ? sh[VW-1:0] : diff[VW-1:0];
			dvd_q <= {dvd_q[DW-2:0], ~diff[VW]};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

// ===== rtl/lbw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbw_front: command intake and configuration
// Takes commands, classifies loads and evaluates, queues them in a two-entry
// fifo, and holds the configuration registers.
// ----------------------------------------------------------------------------
module lbw_front #(
	parameter int MAX_NODES = lbw_pkg::MAX_NODES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire lbw_pkg::in_t   cmd,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [31:0]    cfg_data,
	input  wire logic           pop,
	output logic                q_valid,
	output lbw_pkg::entry_t     q_entry,
	output lbw_pkg::cfg_t       cfg
);
	localparam int CAP = (MAX_NODES < 8) ? MAX_NODES : 8;

	lbw_pkg::entry_t fifo_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            do_pop;
	lbw_pkg::entry_t ent;

	logic [3:0]         node_count_q;
	logic signed [31:0] root_q;
	logic signed [31:0] tip_q;
	logic [24:0]        tol_q;

	assign busy      = (cnt_q == 2'd2);
	assign push      = start && !busy;
	assign do_pop    = pop && (cnt_q != 2'd0);
	assign q_valid   = (cnt_q != 2'd0);
	assign q_entry   = fifo_q[rp_q];
	assign cfg_ready = 1'b1;

	always_comb begin
		ent.is_eval    = (cmd.opcode == lbw_pkg::OP_EVAL);
		ent.wr_ok      = ({2'b00, cmd.node_index} < 5'(MAX_NODES));
		ent.node_index = cmd.node_index;
		ent.coordinate = cmd.coordinate;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (do_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wp_q] <= ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 4'd2;
			root_q       <= -32'sd65536;
			tip_q        <= -32'sd65536;
			tol_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lbw_pkg::REG_NODE_COUNT: node_count_q <= cfg_data[3:0];
				lbw_pkg::REG_BLADE_ROOT: root_q       <= cfg_data;
				lbw_pkg::REG_BLADE_TIP:  tip_q        <= cfg_data;
				lbw_pkg::REG_MATCH_TOL:  tol_q        <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (node_count_q < 4'd2)
			cfg.n = 4'd2;
		else if (node_count_q > 4'(CAP))
			cfg.n = 4'(CAP);
		else
			cfg.n = node_count_q;
		cfg.root = root_q;
		cfg.tip  = tip_q;
		cfg.tol  = tol_q;
	end

endmodule
`default_nettype wire

// ===== rtl/lbw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbw_back: node table and weight sequencer
// Maps point and nodes onto [-1,1], then forms each basis weight with one
// shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
module lbw_back #(
	parameter int MAX_NODES = lbw_pkg::MAX_NODES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire lbw_pkg::entry_t q_entry,
	output logic                 pop,
	input  wire lbw_pkg::cfg_t   cfg,
	output logic                 result_valid,
	output lbw_pkg::out_t        result
);
	localparam int CAP = (MAX_NODES < 8) ? MAX_NODES : 8;
	localparam int AW  = $clog2(MAX_NODES);
	localparam int GW  = $clog2(CAP);
	localparam int DW  = lbw_pkg::DVD_W;
	localparam int VW  = lbw_pkg::DVS_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD0   = 4'd1;
	localparam logic [3:0] S_RDN   = 4'd2;
	localparam logic [3:0] S_MAP   = 4'd3;
	localparam logic [3:0] S_MAPW  = 4'd4;
	localparam logic [3:0] S_GJ    = 4'd5;
	localparam logic [3:0] S_M1    = 4'd6;
	localparam logic [3:0] S_M2    = 4'd7;
	localparam logic [3:0] S_M3    = 4'd8;
	localparam logic [3:0] S_WDIV  = 4'd9;
	localparam logic [3:0] S_WWAIT = 4'd10;
	localparam logic [3:0] S_EMIT  = 4'd11;

	function automatic logic [32:0] sat60(input logic signed [59:0] v);
		if (v > 60'sd2147483647)
			return {1'b1, lbw_pkg::POS_MAX};
		else if (v < -60'sd2147483648)
			return {1'b1, lbw_pkg::NEG_MIN};
		else
			return {1'b0, v[31:0]};
	endfunction

	function automatic logic [32:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31])
			return {1'b1, v[32] ? lbw_pkg::NEG_MIN : lbw_pkg::POS_MAX};
		else
			return {1'b0, v[31:0]};
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : v;
	endfunction

	// magnitude product >> 24, saturated by sign
	function automatic logic [32:0] msat(input logic [63:0] p, input logic neg);
		logic [39:0] m;
		m = p[63:24];
		if (neg) begin
			if (m > 40'h0080000000)
				return {1'b1, lbw_pkg::NEG_MIN};
			else
				return {1'b0, 32'(-m)};
		end else begin
			if (m > 40'h007FFFFFFF)
				return {1'b1, lbw_pkg::POS_MAX};
			else
				return {1'b0, m[31:0]};
		end
	endfunction

	logic [3:0]         st_q;
	logic [3:0]         n_q;
	logic [3:0]         i_q;
	logic [3:0]         j_q;
	logic               map_pt_q;
	logic               map_err_q;
	logic               werr_q;
	logic               qneg_q;
	logic               pneg_q;
	logic signed [31:0] x_q;
	logic signed [31:0] r0_q;
	logic signed [31:0] rn_q;
	logic signed [31:0] s_q;
	logic signed [31:0] gj_q;
	logic signed [31:0] num_q;
	logic signed [31:0] den_q;
	logic signed [31:0] nterm_q;
	logic signed [31:0] w_q;
	logic [63:0]        prod_q;
	logic signed [31:0] tab_q [MAX_NODES];
	logic signed [31:0] g_q [CAP];

	logic                result_valid_q;
	lbw_pkg::out_t       result_q;

	logic [3:0]         tab_addr;
	logic signed [31:0] tab_rd;
	logic [3:0]         g_addr;
	logic signed [31:0] g_rd;

	logic signed [31:0] mx, mlo, mhi;
	logic signed [32:0] mdiff;
	logic signed [33:0] mnum;
	logic signed [32:0] mden;
	logic [33:0]        mnum_mag;
	logic [32:0]        mden_mag;
	logic               mden_zero;

	logic               div_go;
	logic [DW-1:0]      div_dvd;
	logic [VW-1:0]      div_dvs;
	logic               div_done;
	logic [DW-1:0]      div_q;
	logic signed [58:0] qs;

	logic               map_fin;
	logic [32:0]        map_res;
	logic [32:0]        wsat;

	logic signed [32:0] sep;
	logic [32:0]        sep_mag;
	logic [32:0]        dterm;
	logic [32:0]        nterm;
	logic [32:0]        mres;
	logic [3:0]         i_nx;

	// table read port and mapped-node read port
	always_comb begin
		unique case (st_q)
			S_RD0:   tab_addr = 4'd0;
			S_RDN:   tab_addr = n_q - 4'd1;
			default: tab_addr = i_q;
		endcase
		tab_rd = tab_q[tab_addr[AW-1:0]];
		g_addr = (st_q == S_GJ) ? j_q : i_q;
		g_rd   = g_q[g_addr[GW-1:0]];
	end

	// mapping operands
	always_comb begin
		if (map_pt_q) begin
			mx  = x_q;
			mlo = cfg.root[31] ? r0_q : cfg.root;
			mhi = cfg.tip[31] ? rn_q : cfg.tip;
		end else begin
			mx  = tab_rd;
			mlo = r0_q;
			mhi = rn_q;
		end
		mdiff     = {mx[31], mx} - {mlo[31], mlo};
		mnum      = {mdiff, 1'b0};
		mden      = {mhi[31], mhi} - {mlo[31], mlo};
		mnum_mag  = mnum[33] ? 34'(-mnum) : mnum;
		mden_mag  = mden[32] ? 33'(-mden) : mden;
		mden_zero = (mden == '0);
	end

	assign qs   = qneg_q ? 59'(-{1'b0, div_q}) : {1'b0, div_q};
	assign wsat = sat60({qs[58], qs});

	always_comb begin
		map_fin = 1'b0;
		map_res = '0;
		if (st_q == S_MAP && mden_zero) begin
			map_fin = 1'b1;
			if (mnum > 0)
				map_res = {1'b1, lbw_pkg::POS_MAX};
			else if (mnum < 0)
				map_res = {1'b1, lbw_pkg::NEG_MIN};
			else
				map_res = {1'b1, -lbw_pkg::ONE_Q24};
		end else if (st_q == S_MAPW && div_done) begin
			map_fin = 1'b1;
			map_res = sat60({qs[58], qs} - 60'(lbw_pkg::ONE_Q24));
		end
	end

	// divider operand select
	always_comb begin
		div_go  = 1'b0;
		div_dvd = {mnum_mag, 24'd0};
		div_dvs = mden_mag;
		if (st_q == S_MAP && !mden_zero)
			div_go = 1'b1;
		if (st_q == S_WDIV) begin
			div_go  = (den_q != '0);
			div_dvd = {2'b00, mag32(num_q), 24'd0};
			div_dvs = {1'b0, mag32(den_q)};
		end
	end

	lbw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		sep     = {s_q[31], s_q} - {g_rd[31], g_rd};
		sep_mag = sep[32] ? 33'(-sep) : sep;
		dterm   = sat33({gj_q[31], gj_q} - {g_rd[31], g_rd});
		nterm   = sat33({s_q[31], s_q} - {g_rd[31], g_rd});
		mres    = msat(prod_q, pneg_q);
		i_nx    = i_q + 4'd1;
	end

	assign pop = (st_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (q_valid && q_entry.is_eval)
						st_q <= S_RD0;
				end
				S_RD0: st_q <= S_RDN;
				S_RDN: st_q <= S_MAP;
				S_MAP: begin
					if (map_fin) begin
						if (!map_pt_q && i_nx == n_q)
							st_q <= S_GJ;
					end else begin
						st_q <= S_MAPW;
					end
				end
				S_MAPW: begin
					if (map_fin) begin
						if (!map_pt_q && i_nx == n_q)
							st_q <= S_GJ;
						else
							st_q <= S_MAP;
					end
				end
				S_GJ: begin
					if (sep_mag <= {8'd0, cfg.tol})
						st_q <= S_EMIT;
					else
						st_q <= S_M1;
				end
				S_M1: begin
					if (i_q != j_q)
						st_q <= S_M2;
					else if (i_nx == n_q)
						st_q <= S_WDIV;
				end
				S_M2: st_q <= S_M3;
				S_M3: st_q <= (i_nx == n_q) ? S_WDIV : S_M1;
				S_WDIV: st_q <= (den_q == '0) ? S_EMIT : S_WWAIT;
				S_WWAIT: begin
					if (div_done)
						st_q <= S_EMIT;
				end
				S_EMIT: begin
					result_valid_q <= 1'b1;
					st_q <= (j_q == n_q - 4'd1) ? S_IDLE : S_GJ;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				if (q_valid) begin
					if (!q_entry.is_eval) begin
						if (q_entry.wr_ok)
							tab_q[AW'(q_entry.node_index)] <= q_entry.coordinate;
					end else begin
						x_q       <= q_entry.coordinate;
						n_q       <= cfg.n;
						map_err_q <= 1'b0;
					end
				end
			end
			S_RD0: r0_q <= tab_rd;
			S_RDN: begin
				rn_q     <= tab_rd;
				map_pt_q <= 1'b1;
			end
			S_MAP, S_MAPW: begin
				if (st_q == S_MAP)
					qneg_q <= mnum[33] ^ mden[32];
				if (map_fin) begin
					map_err_q <= map_err_q | map_res[32];
					if (map_pt_q) begin
						s_q      <= map_res[31:0];
						map_pt_q <= 1'b0;
						i_q      <= 4'd0;
					end else begin
						g_q[i_q[GW-1:0]] <= map_res[31:0];
						i_q <= i_nx;
						j_q <= 4'd0;
					end
				end
			end
			S_GJ: begin
				gj_q   <= g_rd;
				werr_q <= map_err_q;
				w_q    <= lbw_pkg::ONE_Q24;
				num_q  <= lbw_pkg::ONE_Q24;
				den_q  <= lbw_pkg::ONE_Q24;
				i_q    <= 4'd0;
			end
			S_M1: begin
				if (i_q == j_q) begin
					i_q <= i_nx;
				end else begin
					prod_q  <= mag32(den_q) * mag32(dterm[31:0]);
					pneg_q  <= den_q[31] ^ dterm[31];
					nterm_q <= nterm[31:0];
					werr_q  <= werr_q | dterm[32] | nterm[32];
				end
			end
			S_M2: begin
				den_q  <= mres[31:0];
				werr_q <= werr_q | mres[32];
				prod_q <= mag32(num_q) * mag32(nterm_q);
				pneg_q <= num_q[31] ^ nterm_q[31];
			end
			S_M3: begin
				num_q  <= mres[31:0];
				werr_q <= werr_q | mres[32];
				i_q    <= i_nx;
			end
			S_WDIV: begin
				qneg_q <= num_q[31] ^ den_q[31];
				if (den_q == '0) begin
					werr_q <= 1'b1;
					if (num_q > 0)
						w_q <= lbw_pkg::POS_MAX;
					else if (num_q < 0)
						w_q <= lbw_pkg::NEG_MIN;
					else
						w_q <= '0;
				end
			end
			S_WWAIT: begin
				if (div_done) begin
					w_q    <= wsat[31:0];
					werr_q <= werr_q | wsat[32];
				end
			end
			S_EMIT: begin
				result_q.weight_index        <= j_q[2:0];
				result_q.weight              <= w_q;
				result_q.normalized_position <= s_q;
				result_q.error_flag          <= werr_q;
				result_q.last                <= (j_q == n_q - 4'd1);
				j_q <= j_q + 4'd1;
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ===== rtl/lagrange_basis_weights_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lagrange_basis_weights_unit: lagrange basis weights over a node table
// A load is written into the node table by the back end. An evaluate of n
// nodes maps the point and each node with a division on the shared 58-step
// divider, then per weight multiplies in each other node and divides once;
// a matched node skips that work and a zero span skips its division. One
// result per node, each a single-cycle strobe; the receiver cannot stall.
// A two-word queue takes commands while the back end works. Reset clears
// control and configuration; the node table holds no reset value.
// ----------------------------------------------------------------------------
module lagrange_basis_weights_unit #(
	parameter int MAX_NODES = lbw_pkg::MAX_NODES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire lbw_pkg::in_t  cmd,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [31:0]   cfg_data,
	output logic               result_valid,
	output lbw_pkg::out_t      result
);
	logic            pop;
	logic            q_valid;
	lbw_pkg::entry_t q_entry;
	lbw_pkg::cfg_t   cfg;

	lbw_front #(.MAX_NODES(MAX_NODES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.cfg       (cfg)
	);

	lbw_back #(.MAX_NODES(MAX_NODES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (q_entry),
		.pop          (pop),
		.cfg          (cfg),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire
